>>> rtl/core/rrq_pkg.sv
// ----------------------------------------------------------------------------
// rrq_pkg
// shared sizes, opcodes and entry layout of the signal strength ring queue
// ----------------------------------------------------------------------------
package rrq_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int BATCH_MAX   = 8;

    localparam int IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(BATCH_MAX + 1);
    localparam int SPAN_W = (IDX_W + 1 > CNT_W) ? IDX_W + 1 : CNT_W;
    localparam int OP_W   = 2;

    localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
    localparam logic [OP_W-1:0] OP_DRAIN = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // rssi in the low byte, angle in the high byte
    typedef struct packed {
        logic [7:0]        aoa;
        logic signed [7:0] rssi;
    } entry_t;

    typedef struct packed {
        logic   en;
        idx_t   addr;
        entry_t data;
    } ram_wr_t;

    typedef struct packed {
        logic en;
        idx_t addr;
    } ram_rd_t;

    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } state_t;

endpackage

>>> rtl/core/rrq_in_if.sv
// ----------------------------------------------------------------------------
// rrq_in_if
// command channel: opcode plus sample fields, valid/ready transfer
// ----------------------------------------------------------------------------
interface rrq_in_if import rrq_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic signed [7:0] rssi;
    logic [7:0]        aoa;

    modport source (output valid, output opcode, output rssi, output aoa, input ready);
    modport sink   (input valid, input opcode, input rssi, input aoa, output ready);

endinterface

>>> rtl/core/rrq_out_if.sv
// ----------------------------------------------------------------------------
// rrq_out_if
// result channel: drained entry with batch end and empty markers
// ----------------------------------------------------------------------------
interface rrq_out_if;

    logic              valid;
    logic              ready;
    logic signed [7:0] out_rssi;
    logic [7:0]        out_aoa;
    logic              last;
    logic              queue_empty;

    modport source (output valid, output out_rssi, output out_aoa, output last,
                    output queue_empty, input ready);
    modport sink   (input valid, input out_rssi, input out_aoa, input last,
                    input queue_empty, output ready);

endinterface

>>> rtl/core/rssi_ring_queue_batch_drain.sv
// ----------------------------------------------------------------------------
// rssi_ring_queue_batch_drain
// ring queue of signal strength samples with batched drain
// ----------------------------------------------------------------------------
// A new command is accepted every cycle while no drain is running. A drain of
// n entries (n up to BATCH_MAX and the stored count, cut at the end of the
// store) occupies the block for the command transfer, then one store read
// per cycle through the single read port, with reads held off while the
// result side stalls. An empty queue drain gives one empty marker. The
// result is held in the store's read register, so commands are taken while
// the final result of a drain still waits. The store holds at most
// QUEUE_DEPTH-1 samples and overwrites the oldest when full.
// ----------------------------------------------------------------------------
module rssi_ring_queue_batch_drain import rrq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    rrq_in_if.sink    in_ch,
    rrq_out_if.source out_ch
);

    state_t state_reg, state_next;
    idx_t   rd_idx_reg, rd_idx_next;
    idx_t   wr_idx_reg, wr_idx_next;
    idx_t   drain_addr_reg, drain_addr_next;
    cnt_t   cnt_reg, cnt_next;
    logic   marker_reg, marker_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_last_reg, out_last_next;
    logic   out_empty_reg, out_empty_next;

    logic    take;
    logic    slot_free;
    logic    issue;
    logic    drain_done;
    ram_wr_t ram_wr;
    ram_rd_t ram_rd;
    entry_t  rd_data;

    logic [SPAN_W-1:0] span_diff;
    logic [SPAN_W-1:0] span_dist;
    logic [SPAN_W-1:0] span_n;
    logic [SPAN_W-1:0] span_end;
    idx_t              wr_inc;
    idx_t              rd_inc;

    function automatic idx_t wrap_inc(input idx_t v);
        idx_t r;
        if (v == idx_t'(QUEUE_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = v + idx_t'(1);
        end
        return r;
    endfunction

    rrq_entry_ram u_ram
    (
        .clk     (clk),
        .wr      (ram_wr),
        .rd      (ram_rd),
        .rd_data (rd_data)
    );

    // batch size and read index after the batch
    always_comb
    begin
        span_diff = SPAN_W'(wr_idx_reg) - SPAN_W'(rd_idx_reg);
        span_dist = SPAN_W'(QUEUE_DEPTH) - SPAN_W'(rd_idx_reg);
        span_n    = SPAN_W'(BATCH_MAX);
        if (wr_idx_reg > rd_idx_reg && span_diff < SPAN_W'(BATCH_MAX))
        begin
            span_n = span_diff;
        end
        else if (wr_idx_reg < rd_idx_reg && span_dist < SPAN_W'(BATCH_MAX))
        begin
            span_n = span_dist;
        end
        span_end = SPAN_W'(rd_idx_reg) + span_n;
        wr_inc   = wrap_inc(wr_idx_reg);
        rd_inc   = wrap_inc(rd_idx_reg);
    end

    // fsm outputs
    always_comb
    begin
        slot_free  = !out_valid_reg || out_ch.ready;
        in_ch.ready = 1'b0;
        issue      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ch.ready = 1'b1;
            end
            ST_DRAIN:
            begin
                issue = slot_free;
            end
            default:
            begin
                in_ch.ready = 1'b0;
            end
        endcase
        take       = in_ch.valid && in_ch.ready;
        drain_done = issue && (marker_reg || cnt_reg == cnt_t'(1));
    end

    // fsm next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take && in_ch.opcode == OP_DRAIN)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (drain_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // indices, store access and result register
    always_comb
    begin
        rd_idx_next     = rd_idx_reg;
        wr_idx_next     = wr_idx_reg;
        drain_addr_next = drain_addr_reg;
        cnt_next        = cnt_reg;
        marker_next     = marker_reg;
        out_valid_next  = out_valid_reg && !out_ch.ready;
        out_last_next   = out_last_reg;
        out_empty_next  = out_empty_reg;

        ram_wr.en        = 1'b0;
        ram_wr.addr      = wr_idx_reg;
        ram_wr.data.rssi = in_ch.rssi;
        ram_wr.data.aoa  = in_ch.aoa;
        ram_rd.en        = 1'b0;
        ram_rd.addr      = drain_addr_reg;

        if (take)
        begin
            priority case (in_ch.opcode)
                OP_ADD:
                begin
                    ram_wr.en   = 1'b1;
                    wr_idx_next = wr_inc;
                    // full: drop the oldest sample
                    if (wr_inc == rd_idx_reg)
                    begin
                        rd_idx_next = rd_inc;
                    end
                end
                OP_CLEAR:
                begin
                    rd_idx_next = '0;
                    wr_idx_next = '0;
                end
                OP_DRAIN:
                begin
                    drain_addr_next = rd_idx_reg;
                    cnt_next        = cnt_t'(span_n);
                    if (wr_idx_reg == rd_idx_reg)
                    begin
                        marker_next = 1'b1;
                        rd_idx_next = '0;
                        wr_idx_next = '0;
                    end
                    else
                    begin
                        marker_next = 1'b0;
                        if (span_end == SPAN_W'(QUEUE_DEPTH))
                        begin
                            rd_idx_next = '0;
                        end
                        else
                        begin
                            rd_idx_next = span_end[IDX_W-1:0];
                        end
                    end
                end
                default:
                begin
                    rd_idx_next = rd_idx_reg;
                end
            endcase
        end

        if (issue)
        begin
            out_valid_next = 1'b1;
            out_last_next  = drain_done;
            out_empty_next = marker_reg;
            if (!marker_reg)
            begin
                ram_rd.en       = 1'b1;
                drain_addr_next = drain_addr_reg + idx_t'(1);
                cnt_next        = cnt_reg - cnt_t'(1);
            end
            else
            begin
                marker_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            rd_idx_reg     <= '0;
            wr_idx_reg     <= '0;
            drain_addr_reg <= '0;
            cnt_reg        <= '0;
            marker_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_last_reg   <= 1'b0;
            out_empty_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rd_idx_reg     <= rd_idx_next;
            wr_idx_reg     <= wr_idx_next;
            drain_addr_reg <= drain_addr_next;
            cnt_reg        <= cnt_next;
            marker_reg     <= marker_next;
            out_valid_reg  <= out_valid_next;
            out_last_reg   <= out_last_next;
            out_empty_reg  <= out_empty_next;
        end
    end

    // empty marker carries zero data
    assign out_ch.valid       = out_valid_reg;
    assign out_ch.out_rssi    = out_empty_reg ? 8'sd0 : rd_data.rssi;
    assign out_ch.out_aoa     = out_empty_reg ? 8'd0 : rd_data.aoa;
    assign out_ch.last        = out_last_reg;
    assign out_ch.queue_empty = out_empty_reg;

endmodule

>>> rtl/core/rrq_entry_ram.sv
// ----------------------------------------------------------------------------
// rrq_entry_ram
// sample store, one write and one registered read port
// ----------------------------------------------------------------------------
module rrq_entry_ram import rrq_pkg::*;
(
    input  logic    clk,
    input  ram_wr_t wr,
    input  ram_rd_t rd,
    output entry_t  rd_data
);

    entry_t mem [QUEUE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // read data holds while no read is issued, so it doubles as output payload
    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data <= mem[rd.addr];
        end
    end

endmodule

>>> tb/tb_rssi_ring_queue_batch_drain.sv
// ----------------------------------------------------------------------------
// tb_rssi_ring_queue_batch_drain
// self-checking bench for the signal strength ring queue with batched drain
// ----------------------------------------------------------------------------
// Commands go in through the command channel. A scoreboard keeps its own copy
// of the store and both indices and works out the drained entries for every
// accepted command. Each result transfer is checked field by field against
// the oldest expected entry. A short directed part comes first; then random runs of
// adds, drains, clears and unused opcodes, with a long fill that overwrites the
// oldest samples and drains across the end of the store while results are held
// off. Results idle at random up to the last part, commands too from the fill on.
// ----------------------------------------------------------------------------
module tb_rssi_ring_queue_batch_drain;
    import rrq_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int RANDOM_ITEMS   = 300;
    localparam int QUIET_ITEMS    = 40;
    localparam int HOLD_CYCLES    = 200;
    localparam int SETTLE_CYCLES  = 2 * BATCH_MAX + 8;

    typedef struct {
        logic signed [7:0] rssi;
        logic [7:0]        aoa;
        logic              is_last;
        logic              is_empty;
    } drained_t;

    class drain_scoreboard;
        entry_t      samples [QUEUE_DEPTH];
        int unsigned rd_pos;
        int unsigned wr_pos;
        drained_t    pending [$];
        int          errors;

        function new();
            rd_pos = 0;
            wr_pos = 0;
            errors = 0;
            foreach (samples[i])
                samples[i] = '0;
        endfunction

        function void note_command(logic [OP_W-1:0] op, logic signed [7:0] rssi,
                                   logic [7:0] aoa);
            int unsigned n;
            drained_t    d;
            case (op)
                OP_ADD:
                begin
                    samples[wr_pos].rssi = rssi;
                    samples[wr_pos].aoa  = aoa;
                    wr_pos = (wr_pos + 1) % QUEUE_DEPTH;
                    // full queue drops its oldest sample
                    if (wr_pos == rd_pos)
                        rd_pos = (rd_pos + 1) % QUEUE_DEPTH;
                end
                OP_CLEAR:
                begin
                    rd_pos = 0;
                    wr_pos = 0;
                end
                OP_DRAIN:
                begin
                    if (wr_pos == rd_pos)
                    begin
                        d.rssi     = '0;
                        d.aoa      = '0;
                        d.is_last  = 1'b1;
                        d.is_empty = 1'b1;
                        pending.push_back(d);
                        rd_pos = 0;
                        wr_pos = 0;
                    end
                    else
                    begin
                        n = BATCH_MAX;
                        if (wr_pos > rd_pos && wr_pos - rd_pos < BATCH_MAX)
                            n = wr_pos - rd_pos;
                        else if (wr_pos < rd_pos && QUEUE_DEPTH - rd_pos < BATCH_MAX)
                            n = QUEUE_DEPTH - rd_pos;
                        for (int unsigned k = 0; k < n; k++)
                        begin
                            d.rssi     = samples[(rd_pos + k) % QUEUE_DEPTH].rssi;
                            d.aoa      = samples[(rd_pos + k) % QUEUE_DEPTH].aoa;
                            d.is_last  = (k + 1 == n);
                            d.is_empty = 1'b0;
                            pending.push_back(d);
                        end
                        rd_pos = (rd_pos + n) % QUEUE_DEPTH;
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic signed [7:0] rssi, logic [7:0] aoa,
                                   logic is_last, logic is_empty);
            drained_t want;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result rssi %0d aoa %0d last %0b empty %0b",
                         $time, rssi, aoa, is_last, is_empty);
                return;
            end
            want = pending.pop_front();
            if (rssi !== want.rssi)
            begin
                errors++;
                $display("%0t: out_rssi expected %0d actual %0d", $time, want.rssi, rssi);
            end
            if (aoa !== want.aoa)
            begin
                errors++;
                $display("%0t: out_aoa expected %0d actual %0d", $time, want.aoa, aoa);
            end
            if (is_last !== want.is_last)
            begin
                errors++;
                $display("%0t: last expected %0b actual %0b", $time, want.is_last, is_last);
            end
            if (is_empty !== want.is_empty)
            begin
                errors++;
                $display("%0t: queue_empty expected %0b actual %0b",
                         $time, want.is_empty, is_empty);
            end
        endfunction

        function int outstanding();
            return pending.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic quiet;
    logic hold_start;
    logic tx_bursty;
    int   cycles = 0;
    int   random_count;

    drain_scoreboard sb = new();

    rrq_in_if  in_ch ();
    rrq_out_if out_ch ();

    rssi_ring_queue_batch_drain dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("rssi_ring_queue_batch_drain verification failed");
            $finish;
        end
    end

    function automatic logic signed [7:0] pick_rssi();
        case ($urandom_range(0, 7))
            0: return -8'sd128;
            1: return 8'sd127;
            2: return 8'sd0;
            3: return -8'sd1;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_aoa();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hff;
            2: return 8'h55;
            3: return 8'haa;
            default: return 8'($urandom);
        endcase
    endfunction

    // called just after the clock rises; leaves valid high on return
    task automatic send(input logic [OP_W-1:0] op, input logic signed [7:0] r,
                        input logic [7:0] a);
        in_ch.valid  <= 1'b1;
        in_ch.opcode <= op;
        in_ch.rssi   <= r;
        in_ch.aoa    <= a;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        sb.note_command(op, r, a);
    endtask

    task automatic issue(input logic [OP_W-1:0] op, input logic signed [7:0] r,
                         input logic [7:0] a);
        if (!quiet && tx_bursty && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13))
                @(posedge clk);
        end
        send(op, r, a);
        if (op != OP_UNUSED)
            random_count++;
    endtask

    task automatic random_run();
        int len;
        logic [OP_W-1:0] op;
        tx_bursty = ($urandom_range(0, 2) != 0);
        case ($urandom_range(0, 15))
            0:
            begin
                len = $urandom_range(50, 70);
                repeat (len) issue(OP_ADD, pick_rssi(), pick_aoa());
            end
            1, 2, 3, 4, 5, 6:
            begin
                len = $urandom_range(1, 12);
                repeat (len) issue(OP_ADD, pick_rssi(), pick_aoa());
            end
            7, 8, 9, 10, 11:
            begin
                len = $urandom_range(1, 6);
                repeat (len) issue(OP_DRAIN, 8'($urandom), 8'($urandom));
            end
            12:
                issue(OP_CLEAR, 8'($urandom), 8'($urandom));
            13:
            begin
                len = $urandom_range(1, 3);
                repeat (len) issue(OP_UNUSED, 8'($urandom), 8'($urandom));
            end
            14:
            begin
                len = $urandom_range(1, 10);
                repeat (len)
                begin
                    op = ($urandom_range(0, 2) == 0) ? OP_DRAIN : OP_ADD;
                    issue(op, pick_rssi(), pick_aoa());
                end
            end
            default:
            begin
                len = $urandom_range(1, 8);
                repeat (len)
                begin
                    op = OP_W'($urandom_range(0, 3));
                    issue(op, pick_rssi(), pick_aoa());
                end
            end
        endcase
    endtask

    // result side: checks transfers and drives ready with random stalls
    initial
    begin
        int   stall_left;
        int   hold_left;
        logic held;
        logic rx_bursty;
        stall_left = 0;
        hold_left  = 0;
        held       = 1'b0;
        rx_bursty  = 1'b1;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
                sb.check_result(out_ch.out_rssi, out_ch.out_aoa, out_ch.last,
                                out_ch.queue_empty);
            if ($urandom_range(0, 99) == 0)
                rx_bursty = !rx_bursty;
            if (hold_start && !held)
            begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (!rst_n)
                out_ch.ready <= 1'b0;
            else if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end
            else if (!quiet && rx_bursty && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 13) - 1;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        rst_n        <= 1'b0;
        quiet        <= 1'b0;
        hold_start   <= 1'b0;
        tx_bursty    = 1'b0;
        random_count = 0;
        in_ch.valid  <= 1'b0;
        in_ch.opcode <= OP_ADD;
        in_ch.rssi   <= '0;
        in_ch.aoa    <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty drain, field extremes, short and full batches, clear
        issue(OP_DRAIN, 8'sd0, 8'h00);
        issue(OP_ADD, -8'sd128, 8'h00);
        issue(OP_ADD, 8'sd127, 8'hff);
        issue(OP_ADD, 8'sd0, 8'h55);
        issue(OP_ADD, -8'sd1, 8'haa);
        issue(OP_DRAIN, 8'sd0, 8'h00);
        for (int i = 0; i < 10; i++)
            issue(OP_ADD, 8'(i * 13 - 60), 8'(i * 25));
        issue(OP_DRAIN, 8'sd0, 8'h00);
        issue(OP_DRAIN, 8'sd0, 8'h00);
        issue(OP_DRAIN, 8'sd0, 8'h00);
        issue(OP_ADD, 8'sd5, 8'h12);
        issue(OP_ADD, 8'sd6, 8'h34);
        issue(OP_CLEAR, 8'sd0, 8'h00);
        issue(OP_DRAIN, 8'sd0, 8'h00);
        issue(OP_UNUSED, -8'sd128, 8'hff);
        issue(OP_DRAIN, 8'sd0, 8'h00);
        random_count = 0;

        // overfill, then drain across the end of the store while results are held off
        tx_bursty = 1'b1;
        repeat (70) issue(OP_ADD, pick_rssi(), pick_aoa());
        hold_start <= 1'b1;
        repeat (9) issue(OP_DRAIN, 8'($urandom), 8'($urandom));

        while (random_count < RANDOM_ITEMS - QUIET_ITEMS)
            random_run();
        quiet <= 1'b1;
        while (random_count < RANDOM_ITEMS)
            random_run();
        in_ch.valid <= 1'b0;

        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (sb.outstanding() != 0)
        begin
            sb.errors++;
            $display("%0t: %0d expected results never arrived", $time, sb.outstanding());
        end
        if (sb.errors == 0)
            $display("rssi_ring_queue_batch_drain verification clean");
        else
            $display("rssi_ring_queue_batch_drain verification failed");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/rrq_pkg.sv
rtl/core/rrq_in_if.sv
rtl/core/rrq_out_if.sv
rtl/core/rrq_entry_ram.sv
rtl/core/rssi_ring_queue_batch_drain.sv
tb/tb_rssi_ring_queue_batch_drain.sv
